// ===== hw/rtl/altc_pkg.sv =====
package altc_pkg;

	localparam int TableSize = 8;
	localparam int NameWords = 4;
	localparam int NameBytes = 32;
	localparam int SlotW = 3;
	localparam int CntW = 4;

	typedef logic [NameWords*64-1:0] name_t;

	typedef enum logic [1:0] {
		FUNC_CHECK  = 2'd0,
		FUNC_ADD    = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_NEXT   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_ALLOW_REMOTE = 3'd0,
		REG_DEF_LOCAL    = 3'd1,
		REG_DEF_REMOTE   = 3'd2,
		REG_LOCAL_MASK   = 3'd3,
		REG_REMOTE_MASK  = 3'd4
	} reg_idx_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic                 write;
		logic                 clear;
		logic [SlotW-1:0]     slot;
		name_t                name;
		logic [31:0]          perms;
	} cell_cmd_t;

	// Search result handed along the chain, lowest slot wins.
	typedef struct packed {
		logic                 match_found;
		logic [SlotW-1:0]     match_slot;
		logic                 free_found;
		logic [SlotW-1:0]     free_slot;
		logic                 next_found;
		logic [SlotW-1:0]     next_slot;
		name_t                next_name;
		logic [31:0]          match_perms;
		logic [31:0]          next_perms;
	} chain_t;

	// Cut the key at its first zero byte.
	function automatic name_t normalize(input name_t src);
		name_t k;
		logic ended;
		k = '0;
		ended = 1'b0;
		for (int b = 0; b < NameWords*8; b++) begin
			if (b >= NameBytes || src[b*8 +: 8] == 8'd0) ended = 1'b1;
			if (!ended) k[b*8 +: 8] = src[b*8 +: 8];
		end
		return k;
	endfunction

endpackage

// ===== hw/rtl/altc_cell.sv =====
module altc_cell
	import altc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SlotW-1:0] my_slot,
	input  cell_cmd_t        cmd,
	input  name_t            key,
	input  logic [3:0]       start_index,
	input  chain_t           chain_in,
	output chain_t           chain_out
);

	name_t       name_q;
	logic [31:0] perms_q;
	logic        used;
	logic        hit;
	logic        at_or_after;

	// Slot storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q  <= '0;
			perms_q <= '0;
		end else if (cmd.slot == my_slot) begin
			if (cmd.clear) begin
				name_q  <= '0;
				perms_q <= '0;
			end else if (cmd.write) begin
				name_q  <= cmd.name;
				perms_q <= cmd.perms;
			end
		end
	end

	assign used        = name_q[7:0] != 8'd0;
	assign hit         = name_q == key;
	assign at_or_after = {1'b0, my_slot} >= start_index;

	// Chain runs from the highest slot down, so lower slots override.
	always_comb begin
		chain_out = chain_in;
		if (hit) begin
			chain_out.match_found = 1'b1;
			chain_out.match_slot  = my_slot;
			chain_out.match_perms = perms_q;
		end
		if (!used) begin
			chain_out.free_found = 1'b1;
			chain_out.free_slot  = my_slot;
		end
		if (used && at_or_after) begin
			chain_out.next_found = 1'b1;
			chain_out.next_slot  = my_slot;
			chain_out.next_name  = name_q;
			chain_out.next_perms = perms_q;
		end
	end

endmodule

// ===== hw/rtl/access_list_table_and_check_top.sv =====
// Channel   | Handshake          | Payload
// command   | start / busy       | func, name_word0..3, new_permissions, ...
// result    | done (one cycle)   | status ... user_count
// config    | cfg_valid/cfg_ready| cfg_index, cfg_data
// Each command is handled in order: the key is normalized and registered, then
// the cell chain is searched and the result registered with done.
// busy is high while the chain is searched; a new start is taken after it.
// arst_n clears the table, count, config registers and control flags at once.
// The receiver cannot stall; done lasts exactly one cycle.
module access_list_table_and_check_top
	import altc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [63:0] name_word0,
	input  logic [63:0] name_word1,
	input  logic [63:0] name_word2,
	input  logic [63:0] name_word3,
	input  logic [31:0] new_permissions,
	input  logic [31:0] required_permissions,
	input  logic        is_local,
	input  logic [3:0]  start_index,
	output logic        done,
	output logic [1:0]  status,
	output logic        access_granted,
	output logic [31:0] permissions,
	output logic        used_default,
	output logic [2:0]  entry_index,
	output logic [3:0]  next_index,
	output logic [63:0] out_name_word0,
	output logic [63:0] out_name_word1,
	output logic [63:0] out_name_word2,
	output logic [63:0] out_name_word3,
	output logic [3:0]  user_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic        allow_q;
	logic [31:0] def_local_q, def_remote_q, local_mask_q, remote_mask_q;
	logic        busy_q;
	func_t       func_s1;
	name_t       key_s1;
	logic [31:0] newp_s1, req_s1;
	logic        local_s1;
	logic [3:0]  start_s1;
	logic [CntW-1:0] count_q;
	chain_t      chain [TableSize+1];
	cell_cmd_t   cmd;
	status_t     st;
	logic        granted;
	logic [31:0] perms;
	logic        used_def;
	logic [SlotW-1:0] eidx;
	logic [3:0]  nidx;
	name_t       oname;
	logic [CntW-1:0] count_d;
	logic [31:0] req_full;

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b0;
			def_local_q <= '0;
			def_remote_q <= '0;
			local_mask_q <= '0;
			remote_mask_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALLOW_REMOTE: allow_q <= cfg_data[0];
				REG_DEF_LOCAL:    def_local_q <= cfg_data;
				REG_DEF_REMOTE:   def_remote_q <= cfg_data;
				REG_LOCAL_MASK:   local_mask_q <= cfg_data;
				REG_REMOTE_MASK:  remote_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture stage.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			func_s1  <= func_t'(func);
			key_s1   <= normalize({name_word3, name_word2, name_word1, name_word0});
			newp_s1  <= new_permissions;
			req_s1   <= required_permissions;
			local_s1 <= is_local;
			start_s1 <= start_index;
		end
	end

	// Cell chain.
	assign chain[TableSize] = '0;
	for (genvar g = 0; g < TableSize; g++) begin : g_cell
		altc_cell u_cell (
			.clk(clk), .arst_n(arst_n), .my_slot(SlotW'(g)), .cmd(cmd),
			.key(key_s1), .start_index(start_s1),
			.chain_in(chain[g+1]), .chain_out(chain[g])
		);
	end

	// Resolve the operation from the chain.
	always_comb begin
		st = ST_OK; granted = 1'b0; perms = '0; used_def = 1'b0;
		eidx = '0; nidx = '0; oname = '0; count_d = count_q;
		cmd = '0; cmd.name = key_s1; cmd.perms = newp_s1;
		req_full = req_s1 | (local_s1 ? local_mask_q : remote_mask_q);
		if (func_s1 != FUNC_NEXT && key_s1[7:0] == 8'd0) begin
			st = ST_EMPTY;
		end else begin
			unique case (func_s1)
				FUNC_CHECK: begin
					perms = local_s1 ? def_local_q : def_remote_q;
					if (chain[0].match_found) begin
						perms = chain[0].match_perms;
						eidx  = chain[0].match_slot;
					end else begin
						used_def = 1'b1;
						st = ST_NOTFOUND;
					end
					granted = ((perms & req_full) == req_full) && (local_s1 || allow_q);
				end
				FUNC_ADD: begin
					if (chain[0].match_found) begin
						eidx = chain[0].match_slot;
						cmd.write = 1'b1;
					end else if (chain[0].free_found) begin
						eidx = chain[0].free_slot;
						cmd.write = 1'b1;
						count_d = count_q + 1'b1;
					end else begin
						st = ST_FULL;
					end
					cmd.slot = eidx;
				end
				FUNC_REMOVE: begin
					if (chain[0].match_found) begin
						eidx = chain[0].match_slot;
						cmd.clear = 1'b1;
						if (count_q != '0) count_d = count_q - 1'b1;
					end else begin
						st = ST_NOTFOUND;
					end
					cmd.slot = eidx;
				end
				FUNC_NEXT: begin
					if (chain[0].next_found) begin
						eidx  = chain[0].next_slot;
						nidx  = {1'b0, chain[0].next_slot} + 4'd1;
						perms = chain[0].next_perms;
						oname = chain[0].next_name;
					end else begin
						st = ST_NOTFOUND;
						nidx = (start_s1 < 4'(TableSize)) ? 4'(TableSize) : start_s1;
					end
				end
				default: ;
			endcase
		end
		if (!busy_q) begin
			cmd.write = 1'b0;
			cmd.clear = 1'b0;
			count_d = count_q;
		end
	end

	// Control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done    <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q  <= start && !busy_q;
			done    <= busy_q;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			status <= st;
			access_granted <= granted;
			permissions <= perms;
			used_default <= used_def;
			entry_index <= eidx;
			next_index <= nidx;
			{out_name_word3, out_name_word2, out_name_word1, out_name_word0} <= oname;
			user_count <= count_d;
		end
	end

endmodule
